// ===== hdl/sync_frame_checksum_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame checksum deframer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SFCD_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SFCD_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants and control types of the sync frame checksum deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcd_pkg;

	localparam int BYTE_W      = 8;
	localparam int IDX_W       = 6;
	localparam int FRAME_LEN   = 43;
	// clamp the frame length to the supported range
	localparam int FRAME_LEN_C = (FRAME_LEN < 4) ? 4 : ((FRAME_LEN > 64) ? 64 : FRAME_LEN);
	localparam int STORE_DEPTH = 40;
	localparam int PAY_N       = ((FRAME_LEN_C - 3) > STORE_DEPTH) ? STORE_DEPTH
	                                                              : (FRAME_LEN_C - 3);
	localparam int CNT_W       = $clog2(FRAME_LEN_C);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

	// controller to datapath
	typedef struct packed {
		logic hunt;     // remember the byte seen outside a frame
		logic open;     // sync pair seen, start a frame
		logic collect;  // take a frame byte into sum and store
		logic finish;   // checksum byte taken, start the result phase
		logic adv;      // result taken, move to the next payload byte
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sync_hit;
		logic last_pos;
		logic sum_match;
		logic idx_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/sfcd_ram.sv =====
// ----------------------------------------------------------------------------
// sfcd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then read registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/sfcd_datapath.sv =====
// ----------------------------------------------------------------------------
// sfcd_datapath
// Sync detection, byte counting, running checksum, payload store and
// result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_datapath import sfcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output sts_t                   sts,
	output logic      [BYTE_W-1:0] payload_byte,
	output logic      [IDX_W-1:0]  byte_index,
	output logic                   checksum_ok,
	output logic                   last
);

	logic [BYTE_W-1:0] prev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] sum_q;
	logic [IDX_W-1:0]  idx_q;
	logic              ok_q;
	logic [CNT_W-1:0]  cnt_off;
	logic              store_we;
	logic [IDX_W-1:0]  idx_rd;
	logic [BYTE_W-1:0] rdata;

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (cmd.hunt) begin
			prev_q <= rx_byte;
		end else if (cmd.open) begin
			prev_q <= '0;
			cnt_q  <= CNT_W'(2);
			sum_q  <= SYNC_FIRST + SYNC_SECOND;
		end else if (cmd.collect) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sum_q <= sum_q + rx_byte;
		end
	end

	// result index and kind
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			idx_q <= '0;
			ok_q  <= sts.sum_match;
		end else if (cmd.adv) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// store only the payload bytes that fit
	assign cnt_off  = cnt_q - CNT_W'(2);
	assign store_we = cmd.collect && (32'(cnt_off) < STORE_DEPTH);

	// read ahead so the next result is ready right after a take
	always_comb begin
		if (cmd.finish) begin
			idx_rd = '0;
		end else if (cmd.adv) begin
			idx_rd = idx_q + IDX_W'(1);
		end else begin
			idx_rd = idx_q;
		end
	end

	sfcd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(ADDR_W'(cnt_off)),
		.wdata(rx_byte),
		.raddr(ADDR_W'(idx_rd)),
		.rdata(rdata)
	);

	// status toward the controller
	assign sts.sync_hit  = (prev_q == SYNC_FIRST) && (rx_byte == SYNC_SECOND);
	assign sts.last_pos  = (cnt_q == CNT_W'(FRAME_LEN_C - 1));
	assign sts.sum_match = (sum_q == rx_byte);
	assign sts.idx_last  = (idx_q == IDX_W'(PAY_N - 1));

	// result fields; payload and index are zero on an error result
	assign payload_byte = ok_q ? rdata : '0;
	assign byte_index   = ok_q ? idx_q : '0;
	assign checksum_ok  = ok_q;
	assign last         = !ok_q || sts.idx_last;

endmodule

`default_nettype wire

// ===== hdl/sfcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfcd_ctrl
// Controller: hunts for sync, collects a frame, then delivers its results.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_ctrl import sfcd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_FRAME,
		ST_EMIT_OK,
		ST_EMIT_ERR
	} state_t;

	state_t state_q;
	logic   in_acc;
	logic   out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// decode commands for the datapath
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_HUNT: begin
				cmd.open = in_acc && sts.sync_hit;
				cmd.hunt = in_acc && !sts.sync_hit;
			end
			ST_FRAME: begin
				cmd.finish  = in_acc && sts.last_pos;
				cmd.collect = in_acc && !sts.last_pos;
			end
			ST_EMIT_OK: begin
				cmd.adv = out_acc && !sts.idx_last;
			end
			ST_EMIT_ERR: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// hold state and handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			in_stall  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_HUNT: begin
					if (in_acc && sts.sync_hit) begin
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					if (in_acc && sts.last_pos) begin
						state_q   <= sts.sum_match ? ST_EMIT_OK : ST_EMIT_ERR;
						in_stall  <= 1'b1;
						out_valid <= 1'b1;
					end
				end
				ST_EMIT_OK: begin
					if (out_acc && sts.idx_last) begin
						state_q   <= ST_HUNT;
						in_stall  <= 1'b0;
						out_valid <= 1'b0;
					end
				end
				ST_EMIT_ERR: begin
					if (out_acc) begin
						state_q   <= ST_HUNT;
						in_stall  <= 1'b0;
						out_valid <= 1'b0;
					end
				end
				default: begin
					state_q   <= ST_HUNT;
					in_stall  <= 1'b0;
					out_valid <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sync_frame_checksum_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_frame_checksum_deframer
// Deframes a serial byte stream on a 0x55 0xAA sync pair and checks an
// additive 8-bit checksum before releasing the payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one byte per item.
//   Outside a frame the pair 0x55, 0xAA opens a frame; the frame then holds
//   FRAME_LEN bytes, the last one being the mod-256 sum of all others.
//   Output channel (out_valid, out_stall, payload_byte, byte_index,
//   checksum_ok, last) delivers either the payload bytes of a good frame,
//   the final one flagged by last, or one error item with checksum_ok low.
//   Input bytes are taken one per cycle while hunting or collecting.
//   The first result appears in the cycle after the checksum byte is taken;
//   results then follow one per cycle while the receiver does not stall, set
//   by the single read port of the payload RAM, which is read one entry
//   ahead. in_stall is high for the whole result phase.
//   When the receiver stalls, the current result holds and nothing advances.
//   Reset clears the sync history, frame state and handshake; the payload
//   RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sync_frame_checksum_deframer_defines.svh"

module sync_frame_checksum_deframer import sfcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [BYTE_W-1:0] payload_byte,
	output logic      [IDX_W-1:0]  byte_index,
	output logic                   checksum_ok,
	output logic                   last
);

	cmd_t cmd;
	sts_t sts;

	sfcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfcd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rx_byte     (rx_byte),
		.sts         (sts),
		.payload_byte(payload_byte),
		.byte_index  (byte_index),
		.checksum_ok (checksum_ok),
		.last        (last)
	);

	// no input is taken while results are pending
	`SFCD_ASSERT_SAME(a_no_input_during_results, out_valid, in_stall, "input open during results")
	// an error item is a single zeroed final item
	`SFCD_ASSERT_SAME(a_error_item_shape, out_valid && !checksum_ok,
		last && (payload_byte == '0) && (byte_index == '0), "malformed error item")
	// a taken non-final item is followed by the next index
	`SFCD_ASSERT_NEXT(a_index_advances, out_valid && !out_stall && !last,
		out_valid && (byte_index == $past(byte_index) + IDX_W'(1)), "result index skipped")
	// the final item closes the result phase
	`SFCD_ASSERT_NEXT(a_last_closes, out_valid && !out_stall && last,
		!out_valid && !in_stall, "result phase not closed")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sync frame checksum deframer testbench
// Drives a serial byte stream of noise, broken sync pairs and full frames with
// good and corrupted checksums into the deframer. A scoreboard predicts every
// deframed item and checks the output channel field by field. Both channels
// see random idle bursts.
// ----------------------------------------------------------------------------
module testbench import sfcd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 130;
	localparam int QUIET_FROM   = 100;
	localparam int PAYLOAD_LEN  = FRAME_LEN_C - 3;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic              ok;
		logic              fin;
	} deframed_t;

	// Frame predictor and result checker
	class deframe_checker_t;
		logic [BYTE_W-1:0] hunt_byte;
		bit                framing;
		logic [6:0]        held;
		logic [BYTE_W-1:0] csum;
		logic [BYTE_W-1:0] store [STORE_DEPTH];
		deframed_t         pending_results [$];
		int                errors;
		int                bytes_taken;
		int                good_frames;
		int                bad_frames;
		int                results_seen;

		function new();
			hunt_byte = '0;
			framing = 0;
			held = '0;
			csum = '0;
			errors = 0;
			bytes_taken = 0;
			good_frames = 0;
			bad_frames = 0;
			results_seen = 0;
		endfunction

		// Advance the frame state by one accepted byte and queue any results
		function void take_byte(input logic [BYTE_W-1:0] b);
			int unsigned slot;
			int unsigned n;
			deframed_t   r;
			bytes_taken++;
			if (!framing) begin
				if (hunt_byte == SYNC_FIRST && b == SYNC_SECOND) begin
					framing = 1;
					held = 7'd2;
					csum = SYNC_FIRST + SYNC_SECOND;
					hunt_byte = '0;
				end else begin
					hunt_byte = b;
				end
				return;
			end
			slot = held;
			held = held + 7'd1;
			if (slot + 1 < FRAME_LEN_C) begin
				if (slot >= 2 && slot - 2 < STORE_DEPTH)
					store[slot-2] = b;
				csum = csum + b;
				return;
			end
			// checksum byte closes the frame
			framing = 0;
			if (csum != b) begin
				r = '{data: '0, idx: '0, ok: 1'b0, fin: 1'b1};
				pending_results.push_back(r);
				bad_frames++;
				return;
			end
			n = (FRAME_LEN_C - 3 > STORE_DEPTH) ? STORE_DEPTH : FRAME_LEN_C - 3;
			for (int unsigned k = 0; k < n; k++) begin
				r.data = store[k];
				r.idx = IDX_W'(k);
				r.ok = 1'b1;
				r.fin = (k + 1 == n);
				pending_results.push_back(r);
			end
			good_frames++;
		endfunction

		// Compare one delivered item with the oldest expectation
		function void check_result(input deframed_t got);
			deframed_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected item: payload_byte %0h byte_index %0d checksum_ok %0b last %0b",
					got.data, got.idx, got.ok, got.fin);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.data !== want.data) begin
				$error("payload_byte: expected %0h, actual %0h", want.data, got.data);
				errors++;
			end
			if (got.idx !== want.idx) begin
				$error("byte_index: expected %0d, actual %0d", want.idx, got.idx);
				errors++;
			end
			if (got.ok !== want.ok) begin
				$error("checksum_ok: expected %0b, actual %0b", want.ok, got.ok);
				errors++;
			end
			if (got.fin !== want.fin) begin
				$error("last: expected %0b, actual %0b", want.fin, got.fin);
				errors++;
			end
		endfunction

		function bit busy();
			return pending_results.size() != 0;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] payload_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              checksum_ok;
	logic              last;

	deframe_checker_t sb = new();
	bit               quiet = 0;
	int               random_sent = 0;
	int               idle_cycles = 0;

	sync_frame_checksum_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.checksum_ok  (checksum_ok),
		.last         (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Observe both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && !in_stall)
				sb.take_byte(rx_byte);
			if (out_valid && !out_stall)
				sb.check_result('{data: payload_byte, idx: byte_index, ok: checksum_ok,
					fin: last});
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	// Stall the output in random bursts, never in the quiet tail
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	// Send one byte, with an occasional idle burst ahead of it
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Send a sync pair, a payload and a checksum, optionally corrupted
	task automatic send_frame(input fill_t fill, input bit corrupt);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = SYNC_FIRST + SYNC_SECOND;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		for (int k = 0; k < PAYLOAD_LEN; k++) begin
			case (fill)
				FILL_ZERO: b = '0;
				FILL_ONES: b = '1;
				FILL_SYNC: b = k[0] ? SYNC_SECOND : SYNC_FIRST;
				default: b = BYTE_W'($urandom_range(0, 255));
			endcase
			sum = sum + b;
			send_byte(b);
		end
		if (corrupt)
			sum = sum ^ BYTE_W'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// Hold the sender until every predicted item has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.busy());
	endtask

	initial begin
		int pick;
		bit  mid_drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		mid_drain = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise and broken sync pairs: lone second sync byte, first byte
		// followed by something else, repeated first byte before the pair
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_SECOND);
		send_byte(SYNC_FIRST);
		send_byte(8'h00);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		// sync bytes inside the payload are plain data
		send_frame(FILL_SYNC, 0);
		// history is cleared at frame open, so this byte opens nothing
		send_byte(SYNC_SECOND);
		send_frame(FILL_ZERO, 1);
		send_frame(FILL_ONES, 0);
		wait_drained();

		// Mostly well-formed frames, some corrupted, with noise in between
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= QUIET_FROM)
				quiet = 1;
			if (!mid_drain && random_sent >= RANDOM_ITEMS / 2) begin
				mid_drain = 1;
				wait_drained();
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_frame(FILL_RANDOM, $urandom_range(0, 3) == 0);
				random_sent += FRAME_LEN_C;
			end else if (pick <= 7) begin
				repeat ($urandom_range(1, 6)) begin
					send_byte($urandom_range(0, 3) == 0 ? SYNC_FIRST
						: BYTE_W'($urandom_range(0, 255)));
					random_sent++;
				end
			end else begin
				send_byte(SYNC_FIRST);
				send_byte($urandom_range(0, 1) ? SYNC_FIRST : BYTE_W'($urandom_range(0, 0)));
				random_sent += 2;
			end
		end
		in_valid <= 1'b0;

		// Drain and let the pipeline settle
		do @(posedge clk); while (sb.busy());
		repeat (20) @(posedge clk);
		if (sb.busy()) begin
			$error("%0d predicted items never came out", sb.pending_results.size());
			sb.errors++;
		end

		$display("Sent %0d bytes: %0d good frames and %0d checksum errors predicted,",
			sb.bytes_taken, sb.good_frames, sb.bad_frames);
		$display("%0d deframed items checked against the prediction.", sb.results_seen);
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
